>>> src/ec2d_pkg.sv
// ----------------------------------------------------------------------------
// ec2d_pkg
// Constants, the pipeline record and saturation helpers for the two-disc
// elastic collision pipeline.
// ----------------------------------------------------------------------------
package ec2d_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int RADIUS_BITS = 8;
    localparam int UNIT_BITS   = 16;
    localparam int POS_W       = 21;
    localparam int VEL_W       = 16;
    localparam int RAD_W       = 8;

    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 152;

    localparam int ROOT_W  = 17;
    localparam int RSUM_W  = RADIUS_BITS + 1 + FRAC_BITS;
    localparam int SQIN_W  = 2 * ROOT_W;
    localparam int MASS_W  = 3 * RADIUS_BITS;
    localparam int MT_W    = MASS_W + 1;
    localparam int Q_W     = UNIT_BITS + 1;

    localparam int ST_LOAD   = 0;
    localparam int ST_SQUARE = 1;
    localparam int ST_SUM    = 2;
    localparam int ST_INIT   = 3;
    localparam int ST_SQ0    = 4;
    localparam int ST_UINIT  = ST_SQ0 + ROOT_W;
    localparam int ST_UD0    = ST_UINIT + 1;
    localparam int ST_UNIT   = ST_UD0 + Q_W;
    localparam int ST_VPROD  = ST_UNIT + 1;
    localparam int ST_VNORM  = ST_VPROD + 1;
    localparam int ST_WPROD  = ST_VNORM + 1;
    localparam int ST_DELTA  = ST_WPROD + 1;
    localparam int ST_DPROD  = ST_DELTA + 1;
    localparam int ST_OUT    = ST_DPROD + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

    typedef struct packed {
        logic signed [POS_W-1:0] p1x;
        logic signed [POS_W-1:0] p1y;
        logic signed [POS_W-1:0] p2x;
        logic signed [POS_W-1:0] p2y;
        logic signed [VEL_W-1:0] v1x;
        logic signed [VEL_W-1:0] v1y;
        logic signed [VEL_W-1:0] v2x;
        logic signed [VEL_W-1:0] v2y;
        logic [RADIUS_BITS-1:0]  r1;
        logic [RADIUS_BITS-1:0]  r2;
        logic signed [POS_W:0]   dx;
        logic signed [POS_W:0]   dy;
        logic [RSUM_W-1:0]       rs;
        logic [2*POS_W+1:0]      dx2;
        logic [2*POS_W+1:0]      dy2;
        logic [2*RSUM_W-1:0]     rs2;
        logic [2*RADIUS_BITS-1:0] r1sq;
        logic [2*RADIUS_BITS-1:0] r2sq;
        logic [2*POS_W+1:0]      d2;
        logic                    hit;
        logic [MASS_W-1:0]       m1;
        logic [MASS_W-1:0]       m2;
        logic [MT_W-1:0]         mt;
        logic [SQIN_W-1:0]       sq_rad;
        logic [ROOT_W+1:0]       sq_rem;
        logic [ROOT_W-1:0]       sq_root;
        logic [MT_W:0]           w1_rem;
        logic [Q_W-1:0]          w1_q;
        logic [MT_W:0]           w2_rem;
        logic [Q_W-1:0]          w2_q;
        logic [ROOT_W:0]         ux_rem;
        logic [Q_W-1:0]          ux_q;
        logic [ROOT_W:0]         uy_rem;
        logic [Q_W-1:0]          uy_q;
        logic signed [Q_W:0]     ux;
        logic signed [Q_W:0]     uy;
        logic signed [ROOT_W:0]  ov;
        logic signed [Q_W+VEL_W:0] pa1;
        logic signed [Q_W+VEL_W:0] pb1;
        logic signed [Q_W+VEL_W:0] pa2;
        logic signed [Q_W+VEL_W:0] pb2;
        logic signed [2*Q_W+1:0] ovux;
        logic signed [2*Q_W+1:0] ovuy;
        logic signed [19:0]      dn;
        logic signed [18:0]      cx;
        logic signed [18:0]      cy;
        logic signed [37:0]      t1;
        logic signed [37:0]      t2;
        logic signed [22:0]      d1;
        logic signed [22:0]      dd2;
        logic signed [40:0]      e1x;
        logic signed [40:0]      e1y;
        logic signed [40:0]      e2x;
        logic signed [40:0]      e2y;
    } ec2d_pipe_t;

    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [25:0] x);
        logic signed [25:0] hi;
        logic signed [25:0] lo;
        hi = 26'sd32767;
        lo = -26'sd32768;
        if (x > hi) begin
            return VEL_W'(hi);
        end else if (x < lo) begin
            return VEL_W'(lo);
        end
        return x[VEL_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] x);
        if (x[POS_W] != x[POS_W-1]) begin
            return {x[POS_W], {(POS_W-1){~x[POS_W]}}};
        end
        return x[POS_W-1:0];
    endfunction

endpackage

>>> src/elastic_collision_2d.sv
// ----------------------------------------------------------------------------
// elastic_collision_2d
// Two-disc elastic collision response: contact test, unit normal, exchange of
// normal velocity with mass proportional to radius cubed, overlap push-out.
// ----------------------------------------------------------------------------
// One disc pair enters per clock while no output beat waits. Its result is
// presented on the output from the final stage register, and with m_tready
// high it is taken at the following edge. The depth is set by the bit-serial
// square root of the squared distance (17 stages) followed by the two normal
// divisions (17 stages), with the mass-weight divisions running beside the
// square root. All stages move together; the pipeline stalls as a whole only
// while the output beat waits.
module elastic_collision_2d
    import ec2d_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_radius,
    // second_pos_x, second_pos_y, second_vel_x, second_vel_y, second_radius
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y,
    // new_first_pos_x, new_first_pos_y, new_second_pos_x, new_second_pos_y
    output logic [OUT_DATA_W-1:0] m_tdata,
    // hit
    output logic                  m_tuser
);

    ec2d_pipe_t stage_reg  [NUM_STAGES];
    ec2d_pipe_t stage_next [NUM_STAGES];
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic advance;

    assign advance  = !valid_reg[NUM_STAGES-1] || m_tready;
    assign s_tready = advance;
    assign valid_next = {valid_reg[NUM_STAGES-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= valid_next;
        end
    end

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (advance) begin
                stage_reg[k] <= stage_next[k];
            end
        end

        if (k == ST_LOAD) begin : g_load
            always_comb begin
                stage_next[k]     = '0;
                stage_next[k].p1x = s_tdata[20:0];
                stage_next[k].p1y = s_tdata[41:21];
                stage_next[k].v1x = s_tdata[57:42];
                stage_next[k].v1y = s_tdata[73:58];
                stage_next[k].r1  = s_tdata[74 +: RADIUS_BITS];
                stage_next[k].p2x = s_tdata[102:82];
                stage_next[k].p2y = s_tdata[123:103];
                stage_next[k].v2x = s_tdata[139:124];
                stage_next[k].v2y = s_tdata[155:140];
                stage_next[k].r2  = s_tdata[156 +: RADIUS_BITS];
                stage_next[k].dx  = {s_tdata[20], s_tdata[20:0]}
                                  - {s_tdata[102], s_tdata[102:82]};
                stage_next[k].dx  = -stage_next[k].dx;
                stage_next[k].dy  = {s_tdata[123], s_tdata[123:103]}
                                  - {s_tdata[41], s_tdata[41:21]};
                stage_next[k].rs  = {({1'b0, s_tdata[74 +: RADIUS_BITS]}
                                      + {1'b0, s_tdata[156 +: RADIUS_BITS]}),
                                     {FRAC_BITS{1'b0}}};
            end
        end else if (k == ST_SQUARE) begin : g_square
            always_comb begin
                stage_next[k]      = stage_reg[k-1];
                stage_next[k].dx2  = stage_reg[k-1].dx * stage_reg[k-1].dx;
                stage_next[k].dy2  = stage_reg[k-1].dy * stage_reg[k-1].dy;
                stage_next[k].rs2  = stage_reg[k-1].rs * stage_reg[k-1].rs;
                stage_next[k].r1sq = stage_reg[k-1].r1 * stage_reg[k-1].r1;
                stage_next[k].r2sq = stage_reg[k-1].r2 * stage_reg[k-1].r2;
            end
        end else if (k == ST_SUM) begin : g_sum
            always_comb begin
                stage_next[k]    = stage_reg[k-1];
                stage_next[k].d2 = stage_reg[k-1].dx2 + stage_reg[k-1].dy2;
                stage_next[k].m1 = stage_reg[k-1].r1sq * stage_reg[k-1].r1;
                stage_next[k].m2 = stage_reg[k-1].r2sq * stage_reg[k-1].r2;
            end
        end else if (k == ST_INIT) begin : g_init
            always_comb begin
                stage_next[k]         = stage_reg[k-1];
                stage_next[k].hit     = (stage_reg[k-1].d2 <= {10'd0, stage_reg[k-1].rs2})
                                     && (stage_reg[k-1].d2 != '0);
                stage_next[k].mt      = {1'b0, stage_reg[k-1].m1} + {1'b0, stage_reg[k-1].m2};
                stage_next[k].sq_rad  = stage_reg[k-1].d2[SQIN_W-1:0];
                stage_next[k].sq_rem  = '0;
                stage_next[k].sq_root = '0;
                stage_next[k].w1_rem  = {3'd0, stage_reg[k-1].m1[MASS_W-1:1]};
                stage_next[k].w1_q    = {stage_reg[k-1].m1[0], {UNIT_BITS{1'b0}}};
                stage_next[k].w2_rem  = {3'd0, stage_reg[k-1].m2[MASS_W-1:1]};
                stage_next[k].w2_q    = {stage_reg[k-1].m2[0], {UNIT_BITS{1'b0}}};
            end
        end else if (k >= ST_SQ0 && k < ST_UINIT) begin : g_sqrt
            always_comb begin
                logic [ROOT_W+3:0] rem_sh;
                logic [ROOT_W+1:0] trial;
                logic [MT_W:0]     w1_sh;
                logic [MT_W:0]     w2_sh;
                stage_next[k] = stage_reg[k-1];
                rem_sh = {stage_reg[k-1].sq_rem, stage_reg[k-1].sq_rad[SQIN_W-1 -: 2]};
                trial  = {stage_reg[k-1].sq_root, 2'b01};
                stage_next[k].sq_rad = {stage_reg[k-1].sq_rad[SQIN_W-3:0], 2'b00};
                if (rem_sh >= {2'b00, trial}) begin
                    stage_next[k].sq_rem  = (ROOT_W+2)'(rem_sh - {2'b00, trial});
                    stage_next[k].sq_root = {stage_reg[k-1].sq_root[ROOT_W-2:0], 1'b1};
                end else begin
                    stage_next[k].sq_rem  = rem_sh[ROOT_W+1:0];
                    stage_next[k].sq_root = {stage_reg[k-1].sq_root[ROOT_W-2:0], 1'b0};
                end
                w1_sh = {stage_reg[k-1].w1_rem[MT_W-1:0], stage_reg[k-1].w1_q[Q_W-1]};
                w2_sh = {stage_reg[k-1].w2_rem[MT_W-1:0], stage_reg[k-1].w2_q[Q_W-1]};
                if (w1_sh >= {1'b0, stage_reg[k-1].mt}) begin
                    stage_next[k].w1_rem = w1_sh - {1'b0, stage_reg[k-1].mt};
                    stage_next[k].w1_q   = {stage_reg[k-1].w1_q[Q_W-2:0], 1'b1};
                end else begin
                    stage_next[k].w1_rem = w1_sh;
                    stage_next[k].w1_q   = {stage_reg[k-1].w1_q[Q_W-2:0], 1'b0};
                end
                if (w2_sh >= {1'b0, stage_reg[k-1].mt}) begin
                    stage_next[k].w2_rem = w2_sh - {1'b0, stage_reg[k-1].mt};
                    stage_next[k].w2_q   = {stage_reg[k-1].w2_q[Q_W-2:0], 1'b1};
                end else begin
                    stage_next[k].w2_rem = w2_sh;
                    stage_next[k].w2_q   = {stage_reg[k-1].w2_q[Q_W-2:0], 1'b0};
                end
            end
        end else if (k == ST_UINIT) begin : g_uinit
            always_comb begin
                logic [POS_W:0] dxa;
                logic [POS_W:0] dya;
                stage_next[k] = stage_reg[k-1];
                dxa = stage_reg[k-1].dx[POS_W] ? -stage_reg[k-1].dx : stage_reg[k-1].dx;
                dya = stage_reg[k-1].dy[POS_W] ? -stage_reg[k-1].dy : stage_reg[k-1].dy;
                stage_next[k].ux_rem = {2'b00, dxa[ROOT_W-1:1]};
                stage_next[k].ux_q   = {dxa[0], {UNIT_BITS{1'b0}}};
                stage_next[k].uy_rem = {2'b00, dya[ROOT_W-1:1]};
                stage_next[k].uy_q   = {dya[0], {UNIT_BITS{1'b0}}};
            end
        end else if (k >= ST_UD0 && k < ST_UNIT) begin : g_udiv
            always_comb begin
                logic [ROOT_W:0] x_sh;
                logic [ROOT_W:0] y_sh;
                stage_next[k] = stage_reg[k-1];
                x_sh = {stage_reg[k-1].ux_rem[ROOT_W-1:0], stage_reg[k-1].ux_q[Q_W-1]};
                y_sh = {stage_reg[k-1].uy_rem[ROOT_W-1:0], stage_reg[k-1].uy_q[Q_W-1]};
                if (x_sh >= {1'b0, stage_reg[k-1].sq_root}) begin
                    stage_next[k].ux_rem = x_sh - {1'b0, stage_reg[k-1].sq_root};
                    stage_next[k].ux_q   = {stage_reg[k-1].ux_q[Q_W-2:0], 1'b1};
                end else begin
                    stage_next[k].ux_rem = x_sh;
                    stage_next[k].ux_q   = {stage_reg[k-1].ux_q[Q_W-2:0], 1'b0};
                end
                if (y_sh >= {1'b0, stage_reg[k-1].sq_root}) begin
                    stage_next[k].uy_rem = y_sh - {1'b0, stage_reg[k-1].sq_root};
                    stage_next[k].uy_q   = {stage_reg[k-1].uy_q[Q_W-2:0], 1'b1};
                end else begin
                    stage_next[k].uy_rem = y_sh;
                    stage_next[k].uy_q   = {stage_reg[k-1].uy_q[Q_W-2:0], 1'b0};
                end
            end
        end else if (k == ST_UNIT) begin : g_unit
            always_comb begin
                stage_next[k]    = stage_reg[k-1];
                stage_next[k].ux = stage_reg[k-1].dx[POS_W] ? -$signed({1'b0, stage_reg[k-1].ux_q})
                                                            : $signed({1'b0, stage_reg[k-1].ux_q});
                stage_next[k].uy = stage_reg[k-1].dy[POS_W] ? -$signed({1'b0, stage_reg[k-1].uy_q})
                                                            : $signed({1'b0, stage_reg[k-1].uy_q});
                stage_next[k].ov = $signed({1'b0, stage_reg[k-1].rs})
                                 - $signed({1'b0, stage_reg[k-1].sq_root});
            end
        end else if (k == ST_VPROD) begin : g_vprod
            always_comb begin
                stage_next[k]      = stage_reg[k-1];
                stage_next[k].pa1  = stage_reg[k-1].ux * stage_reg[k-1].v1x;
                stage_next[k].pb1  = stage_reg[k-1].uy * stage_reg[k-1].v1y;
                stage_next[k].pa2  = stage_reg[k-1].ux * stage_reg[k-1].v2x;
                stage_next[k].pb2  = stage_reg[k-1].uy * stage_reg[k-1].v2y;
                stage_next[k].ovux = stage_reg[k-1].ov * stage_reg[k-1].ux;
                stage_next[k].ovuy = stage_reg[k-1].ov * stage_reg[k-1].uy;
            end
        end else if (k == ST_VNORM) begin : g_vnorm
            always_comb begin
                logic signed [Q_W+VEL_W+1:0] s1;
                logic signed [Q_W+VEL_W+1:0] s2;
                logic signed [18:0] n1;
                logic signed [18:0] n2;
                stage_next[k] = stage_reg[k-1];
                s1 = {stage_reg[k-1].pa1[Q_W+VEL_W], stage_reg[k-1].pa1}
                   + {stage_reg[k-1].pb1[Q_W+VEL_W], stage_reg[k-1].pb1};
                s2 = {stage_reg[k-1].pa2[Q_W+VEL_W], stage_reg[k-1].pa2}
                   + {stage_reg[k-1].pb2[Q_W+VEL_W], stage_reg[k-1].pb2};
                n1 = s1[Q_W+VEL_W+1:UNIT_BITS];
                n2 = s2[Q_W+VEL_W+1:UNIT_BITS];
                stage_next[k].dn = {n2[18], n2} - {n1[18], n1};
                if (stage_reg[k-1].ov > 0) begin
                    stage_next[k].cx = stage_reg[k-1].ovux[2*Q_W+1:UNIT_BITS+1];
                    stage_next[k].cy = stage_reg[k-1].ovuy[2*Q_W+1:UNIT_BITS+1];
                end else begin
                    stage_next[k].cx = '0;
                    stage_next[k].cy = '0;
                end
            end
        end else if (k == ST_WPROD) begin : g_wprod
            always_comb begin
                stage_next[k]    = stage_reg[k-1];
                stage_next[k].t1 = $signed({1'b0, stage_reg[k-1].w2_q}) * stage_reg[k-1].dn;
                stage_next[k].t2 = $signed({1'b0, stage_reg[k-1].w1_q}) * stage_reg[k-1].dn;
            end
        end else if (k == ST_DELTA) begin : g_delta
            always_comb begin
                logic signed [38:0] neg_t2;
                stage_next[k]     = stage_reg[k-1];
                neg_t2            = -{stage_reg[k-1].t2[37], stage_reg[k-1].t2};
                stage_next[k].d1  = stage_reg[k-1].t1[37:15];
                stage_next[k].dd2 = neg_t2[37:15];
            end
        end else if (k == ST_DPROD) begin : g_dprod
            always_comb begin
                stage_next[k]     = stage_reg[k-1];
                stage_next[k].e1x = stage_reg[k-1].d1 * stage_reg[k-1].ux;
                stage_next[k].e1y = stage_reg[k-1].d1 * stage_reg[k-1].uy;
                stage_next[k].e2x = stage_reg[k-1].dd2 * stage_reg[k-1].ux;
                stage_next[k].e2y = stage_reg[k-1].dd2 * stage_reg[k-1].uy;
            end
        end else begin : g_out
            always_comb begin
                ec2d_pipe_t s;
                s = stage_reg[k-1];
                stage_next[k] = s;
                if (s.hit) begin
                    stage_next[k].v1x = sat_vel({{10{s.v1x[15]}}, s.v1x}
                                        + {s.e1x[40], s.e1x[40:16]});
                    stage_next[k].v1y = sat_vel({{10{s.v1y[15]}}, s.v1y}
                                        + {s.e1y[40], s.e1y[40:16]});
                    stage_next[k].v2x = sat_vel({{10{s.v2x[15]}}, s.v2x}
                                        + {s.e2x[40], s.e2x[40:16]});
                    stage_next[k].v2y = sat_vel({{10{s.v2y[15]}}, s.v2y}
                                        + {s.e2y[40], s.e2y[40:16]});
                    stage_next[k].p1x = sat_pos({s.p1x[20], s.p1x}
                                        - {{3{s.cx[18]}}, s.cx});
                    stage_next[k].p1y = sat_pos({s.p1y[20], s.p1y}
                                        - {{3{s.cy[18]}}, s.cy});
                    stage_next[k].p2x = sat_pos({s.p2x[20], s.p2x}
                                        + {{3{s.cx[18]}}, s.cx});
                    stage_next[k].p2y = sat_pos({s.p2y[20], s.p2y}
                                        + {{3{s.cy[18]}}, s.cy});
                end
            end
        end
    end

    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tuser  = stage_reg[NUM_STAGES-1].hit;
    assign m_tdata  = {4'd0,
                       stage_reg[NUM_STAGES-1].p2y, stage_reg[NUM_STAGES-1].p2x,
                       stage_reg[NUM_STAGES-1].p1y, stage_reg[NUM_STAGES-1].p1x,
                       stage_reg[NUM_STAGES-1].v2y, stage_reg[NUM_STAGES-1].v2x,
                       stage_reg[NUM_STAGES-1].v1y, stage_reg[NUM_STAGES-1].v1x};

endmodule
